/* rtl/pit_pkg.sv */
// types and helpers shared by the integer text parser modules
`timescale 1ns / 1ps

package pit_pkg;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_ZERO,
    PH_DIGIT,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    BASE_BIN,
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } base_t;

  typedef struct packed {
    phase_t      phase;
    base_t       base;
    logic [31:0] acc;
    logic [7:0]  count;
  } parse_state_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // 16 marks a byte that is no digit in any base
  localparam logic [4:0] NO_DIGIT = 5'd16;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
    end else begin
      d = {3'd0, NO_DIGIT};
    end
    return d[4:0];
  endfunction

  function automatic logic [4:0] radix_of(input base_t b);
    logic [4:0] r;
    case (b)
      BASE_BIN: r = 5'd2;
      BASE_OCT: r = 5'd8;
      BASE_DEC: r = 5'd10;
      BASE_HEX: r = 5'd16;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

  localparam parse_state_t STATE_RESET = '{
    phase: PH_BLANK,
    base:  BASE_DEC,
    acc:   32'd0,
    count: 8'd0
  };

endpackage

/* rtl/pit_step.sv */
// next parser state for one non-terminator character
`timescale 1ns / 1ps

module pit_step import pit_pkg::*; #(
  parameter int MAX_COUNT = 255
) (
  input  parse_state_t cur,
  input  logic [7:0]   text_byte,
  output parse_state_t nxt
);

  localparam int         LIMIT_INT   = (MAX_COUNT > 255) ? 255 : MAX_COUNT;
  localparam logic [7:0] COUNT_LIMIT = 8'(LIMIT_INT);

  logic [4:0]  digit;
  base_t       take_base;
  logic        is_digit;
  logic [31:0] scaled;
  logic [7:0]  count_inc;
  logic        is_x;
  logic        is_b;

  assign digit     = digit_of(text_byte);
  assign is_x      = (text_byte == CH_LX) || (text_byte == CH_UX);
  assign is_b      = (text_byte == CH_LB) || (text_byte == CH_UB);
  assign count_inc = (cur.count < COUNT_LIMIT) ? cur.count + 8'd1 : cur.count;

  // base the character is judged against when it is taken as a digit
  always_comb begin
    case (cur.phase)
      PH_BLANK: take_base = BASE_DEC;
      PH_ZERO:  take_base = BASE_OCT;
      default:  take_base = cur.base;
    endcase
  end

  assign is_digit = digit < radix_of(take_base);

  // value * base by shifts, wraps at 32 bits
  always_comb begin
    case (take_base)
      BASE_BIN: scaled = {cur.acc[30:0], 1'b0};
      BASE_OCT: scaled = {cur.acc[28:0], 3'b000};
      BASE_DEC: scaled = {cur.acc[28:0], 3'b000} + {cur.acc[30:0], 1'b0};
      BASE_HEX: scaled = {cur.acc[27:0], 4'b0000};
      default:  scaled = cur.acc;
    endcase
  end

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_BLANK: begin
        if (text_byte == CH_SPACE || text_byte == CH_TAB) begin
          nxt.count = count_inc;
        end else if (text_byte == CH_ZERO) begin
          nxt.count = count_inc;
          nxt.phase = PH_ZERO;
        end else begin
          nxt.base = take_base;
          if (is_digit) begin
            nxt.phase = PH_DIGIT;
            nxt.acc   = scaled + {27'd0, digit};
            nxt.count = count_inc;
          end else begin
            nxt.phase = PH_SKIP;
          end
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          nxt.base  = BASE_HEX;
          nxt.count = count_inc;
          nxt.phase = PH_DIGIT;
        end else if (is_b) begin
          nxt.base  = BASE_BIN;
          nxt.count = count_inc;
          nxt.phase = PH_DIGIT;
        end else begin
          nxt.base = take_base;
          if (is_digit) begin
            nxt.phase = PH_DIGIT;
            nxt.acc   = scaled + {27'd0, digit};
            nxt.count = count_inc;
          end else begin
            nxt.phase = PH_SKIP;
          end
        end
      end
      PH_DIGIT: begin
        if (is_digit) begin
          nxt.acc   = scaled + {27'd0, digit};
          nxt.count = count_inc;
        end else begin
          nxt.phase = PH_SKIP;
        end
      end
      default: begin
        nxt.phase = PH_SKIP;
      end
    endcase
  end

endmodule

/* rtl/prefixed_integer_text_parser.sv */
// top level of the prefixed integer text parser
//
// text arrives one byte per beat on the in_ channel (valid/ready); a zero
// byte ends the string and produces one beat on the out_ channel carrying
// the parsed value and the count of characters consumed (blanks, prefix and
// digits, held at the smaller of MAX_COUNT and 255). other bytes produce
// no output beat.
// every byte is handled by the combinational step logic feeding the parse
// state register, so one byte can be taken each cycle while in_ready is
// high; the result of a terminator appears on out_ the cycle after it is
// taken. input is taken whenever the output register is empty or is being
// drained in the same cycle, so a stalled receiver holds off only bytes
// while a result waits.
// after reset the parser waits for leading blanks in base ten with a zero
// value and count, and the output register is empty. each terminator puts
// the parser back in that state for the next string.
`timescale 1ns / 1ps

module prefixed_integer_text_parser import pit_pkg::*; #(
  parameter int MAX_COUNT = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_parsed_value,
  output logic [7:0]         out_consumed_count
);

  parse_state_t       state_r;
  parse_state_t       state_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic signed [31:0] value_r;
  logic [7:0]         count_r;
  logic               in_fire;
  logic               is_end;

  pit_step #(
    .MAX_COUNT(MAX_COUNT)
  ) u_step (
    .cur       (state_r),
    .text_byte (in_text_byte),
    .nxt       (state_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_end   = (in_text_byte == CH_NUL);

  // a terminator beat refills the output register, otherwise it holds until drained
  assign out_valid_nxt = (in_fire && is_end) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        if (is_end) begin
          state_r <= STATE_RESET;
        end else begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // result payload, loaded on a terminator beat
  always_ff @(posedge clk) begin
    if (in_fire && is_end) begin
      value_r <= $signed(state_r.acc);
      count_r <= state_r.count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_parsed_value   = value_r;
  assign out_consumed_count = count_r;

endmodule

/* sim/prefixed_integer_text_parser_test.sv */
// testbench for the prefixed integer text parser: directed strings, then random ones
`timescale 1ns / 1ps

module prefixed_integer_text_parser_test;
  import pit_pkg::*;

  localparam int COUNT_MAX    = 255;
  localparam int COUNT_CAP    = (COUNT_MAX > 255) ? 255 : COUNT_MAX;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [7:0] char_t;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  count;
  } parse_result_t;

  typedef struct {
    string       txt;
    bit          typed;
    logic [31:0] value;
    logic [7:0]  count;
  } text_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_text_byte = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_parsed_value;
  logic [7:0]         out_consumed_count;

  prefixed_integer_text_parser #(
    .MAX_COUNT(COUNT_MAX)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_byte       (in_text_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_parsed_value   (out_parsed_value),
    .out_consumed_count (out_consumed_count)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // parser state as the block should hold it
  phase_t      prs_phase = PH_BLANK;
  logic [4:0]  prs_radix = 5'd10;
  logic [31:0] prs_value = 32'd0;
  logic [7:0]  prs_count = 8'd0;

  parse_result_t expected_results[$];
  int            err_count = 0;
  int            stall_cycles = 0;
  int            tx_idle_pct = 10;
  int            rx_idle_pct = 77;

  function automatic logic [4:0] digit_weight(input char_t c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    return 5'd16;
  endfunction

  function automatic void bump_count();
    if (prs_count < COUNT_CAP) prs_count++;
  endfunction

  function automatic void accept_digit(input char_t c);
    logic [4:0] w;
    w = digit_weight(c);
    if (w >= prs_radix) begin
      prs_phase = PH_SKIP;
    end else begin
      prs_value = prs_value * prs_radix + 32'(w);
      bump_count();
    end
  endfunction

  // advance the parser by one byte; a terminator yields a result
  function automatic bit parse_byte(input char_t c, output parse_result_t res);
    res = '0;
    if (c == CH_NUL) begin
      res = '{value: prs_value, count: prs_count};
      prs_phase = PH_BLANK;
      prs_radix = 5'd10;
      prs_value = 32'd0;
      prs_count = 8'd0;
      return 1'b1;
    end
    case (prs_phase)
      PH_BLANK: begin
        if (c == CH_SPACE || c == CH_TAB) begin
          bump_count();
        end else if (c == CH_ZERO) begin
          bump_count();
          prs_phase = PH_ZERO;
        end else begin
          prs_radix = 5'd10;
          prs_phase = PH_DIGIT;
          accept_digit(c);
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          prs_radix = 5'd16;
          bump_count();
          prs_phase = PH_DIGIT;
        end else if (c == CH_LB || c == CH_UB) begin
          prs_radix = 5'd2;
          bump_count();
          prs_phase = PH_DIGIT;
        end else begin
          prs_radix = 5'd8;
          prs_phase = PH_DIGIT;
          accept_digit(c);
        end
      end
      PH_DIGIT: accept_digit(c);
      default:  prs_phase = PH_SKIP;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result checker and stall watchdog
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_parsed_value, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_parsed_value !== want.value)
            report_mismatch("parsed value", out_parsed_value, want.value);
          if (out_consumed_count !== want.count)
            report_mismatch("consumed count", 32'(out_consumed_count), 32'(want.count));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_byte(input char_t c);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      in_text_byte = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_text_byte = c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sends the text and its terminator; typed rows supply their own result
  task automatic send_text(input char_t text_q[$], input bit typed,
                           input logic [31:0] value, input logic [7:0] count);
    parse_result_t res;
    for (int i = 0; i <= text_q.size(); i++) begin
      send_byte(i < text_q.size() ? text_q[i] : CH_NUL);
      if (parse_byte(i < text_q.size() ? text_q[i] : CH_NUL, res))
        expected_results.push_back(typed ? parse_result_t'{value, count} : res);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic char_t digit_char(input int radix);
    int v;
    v = $urandom_range(radix - 1);
    if (v < 10) return char_t'("0" + v);
    return char_t'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  function automatic void random_text(ref char_t text_q[$]);
    int form;
    int radix;
    int ndig;
    int nblank;
    text_q = {};
    form = $urandom_range(99);
    if (form < 12) begin
      // raw noise
      repeat ($urandom_range(6)) text_q.push_back(char_t'($urandom_range(1, 255)));
      return;
    end
    nblank = (form >= 87) ? $urandom_range(20, 40) : $urandom_range(3);
    repeat (nblank) text_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    ndig = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(10);
    radix = 10;
    if (form < 30 || form >= 87) begin
      text_q.push_back(char_t'("0" + $urandom_range(1, 9)));
    end else if (form < 50) begin
      radix = 16;
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
    end else if (form < 65) begin
      radix = 2;
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(1) ? CH_LB : CH_UB);
    end else if (form < 80) begin
      radix = 8;
      text_q.push_back(CH_ZERO);
    end else begin
      text_q.push_back(CH_ZERO);
      ndig = 0;
    end
    repeat (ndig) text_q.push_back(digit_char(radix));
    if ($urandom_range(1))
      repeat ($urandom_range(1, 3)) text_q.push_back(char_t'($urandom_range(1, 255)));
  endfunction

  text_row_t text_rows[] = '{
    '{"",           1'b1, 32'd0,          8'd0},
    '{"0",          1'b1, 32'd0,          8'd1},
    '{"\t9",        1'b1, 32'd9,          8'd2},
    '{" 0Xg",       1'b1, 32'd0,          8'd3},
    '{"0b12",       1'b1, 32'd1,          8'd3},
    '{"08",         1'b1, 32'd0,          8'd1},
    '{"z",          1'b1, 32'd0,          8'd0},
    '{"\377",       1'b1, 32'd0,          8'd0},
    '{"0xFFFFFFFF", 1'b1, 32'hFFFF_FFFF,  8'd10},
    '{"0177",       1'b0, 32'd0,          8'd0},
    '{"0x7fEa",     1'b0, 32'd0,          8'd0}
  };

  initial begin
    char_t text_q[$];
    int    items_sent;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (text_rows[r]) begin
      text_q = {};
      for (int i = 0; i < text_rows[r].txt.len(); i++) text_q.push_back(text_rows[r].txt[i]);
      send_text(text_q, text_rows[r].typed, text_rows[r].value, text_rows[r].count);
    end
    hold_until_drained();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (items_sent * 3 / RANDOM_ITEMS)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 77;
        end
        1: begin
          tx_idle_pct = 77;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      random_text(text_q);
      send_text(text_q, 1'b0, 32'd0, 8'd0);
      items_sent += text_q.size() + 1;
      if ($urandom_range(9) == 0) hold_until_drained();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
